### sv/hc_pkg.sv
package hc_pkg;

	// Alphabet size and letter width.
	localparam int unsigned Modulus   = 26;
	localparam int unsigned LetterW   = 5;
	// Products and sums of letters stay below 2048.
	localparam int unsigned WideW     = 11;
	// Rounded-up 2^16 / 26, used for the reciprocal reduction.
	localparam int unsigned Recip26   = 2521;
	localparam int unsigned RecipShift = 16;
	// Bias that keeps the determinant difference positive (a multiple of 26).
	localparam int unsigned DetBias   = 650;

	// Key register indexes on the configuration port.
	localparam logic [1:0] IdxKey00 = 2'd0;
	localparam logic [1:0] IdxKey01 = 2'd1;
	localparam logic [1:0] IdxKey10 = 2'd2;
	localparam logic [1:0] IdxKey11 = 2'd3;

	// Key values after reset.
	localparam logic [LetterW-1:0] Key00Rst = 5'd6;
	localparam logic [LetterW-1:0] Key01Rst = 5'd24;
	localparam logic [LetterW-1:0] Key10Rst = 5'd1;
	localparam logic [LetterW-1:0] Key11Rst = 5'd16;

	// Mode codes.
	localparam logic ModeEncrypt = 1'b0;
	localparam logic ModeDecrypt = 1'b1;

	typedef logic [LetterW-1:0] letter_t;

	typedef struct packed {
		letter_t k00;
		letter_t k01;
		letter_t k10;
		letter_t k11;
	} key_t;

	// Reduce a 5-bit value into 0..25 with one compare and subtract.
	function automatic letter_t reduce5(input letter_t v);
		letter_t r;
		r = (v >= letter_t'(Modulus)) ? v - letter_t'(Modulus) : v;
		return r;
	endfunction

	// Modulo 26 of an 11-bit value through a multiply by the reciprocal.
	function automatic letter_t mod26(input logic [WideW-1:0] v);
		logic [22:0]      prod;
		logic [6:0]       q;
		logic [WideW-1:0] r;
		prod = {12'd0, v} * 23'(Recip26);
		q    = prod[22:RecipShift];
		r    = v - WideW'(q) * WideW'(Modulus);
		return r[LetterW-1:0];
	endfunction

	// Additive inverse of a residue in 0..25.
	function automatic letter_t neg26(input letter_t v);
		letter_t r;
		r = (v == '0) ? '0 : letter_t'(Modulus) - v;
		return r;
	endfunction

	// Multiplicative inverse modulo 26; zero means there is none.
	function automatic letter_t inv26(input letter_t d);
		letter_t r;
		case (d)
			5'd1:    r = 5'd1;
			5'd3:    r = 5'd9;
			5'd5:    r = 5'd21;
			5'd7:    r = 5'd15;
			5'd9:    r = 5'd3;
			5'd11:   r = 5'd19;
			5'd15:   r = 5'd7;
			5'd17:   r = 5'd23;
			5'd19:   r = 5'd11;
			5'd21:   r = 5'd5;
			5'd23:   r = 5'd17;
			5'd25:   r = 5'd25;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

### sv/hc_key_regs.sv
module hc_key_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [4:0]    cfg_data,
	output hc_pkg::key_t  key
);
	import hc_pkg::*;

	key_t key_q;

	// The key registers take a write in any cycle.
	assign cfg_ready = 1'b1;
	assign key       = key_q;

	// Register file for the four key elements.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q.k00 <= Key00Rst;
			key_q.k01 <= Key01Rst;
			key_q.k10 <= Key10Rst;
			key_q.k11 <= Key11Rst;
		end else if (cfg_valid) begin
			case (cfg_index)
				IdxKey00: key_q.k00 <= cfg_data;
				IdxKey01: key_q.k01 <= cfg_data;
				IdxKey10: key_q.k10 <= cfg_data;
				IdxKey11: key_q.k11 <= cfg_data;
				default:  key_q     <= key_q;
			endcase
		end
	end

endmodule

### sv/hill_cipher_2x2_pair.sv
// 2x2 Hill cipher on letter pairs, modulo 26. Each request carries one pair
// and a mode; encryption multiplies the pair by the key, decryption derives
// the inverse key per request and multiplies by that. A key with no inverse
// gives key_error and zero letters on decrypt. The datapath is a six-stage
// pipeline (key reduction, determinant products, determinant reduction and
// inverse lookup, inverse key, matrix products, final reduction), and one
// pair is accepted every cycle while the output is not held back by
// m_tready.
// Stages advance independently, so empty stages close up while the output
// waits. Key writes are taken at once and apply to requests accepted after
// the write.
module hill_cipher_2x2_pair (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data,
	// Input pairs.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [4:0] first_letter, [9:5] second_letter, rest zero
	input  logic [1:0]  s_tuser,  // [0] mode, [1] second_present
	// Result pairs.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [4:0] out_first, [9:5] out_second, rest zero
	output logic        m_tuser   // [0] key_error
);
	import hc_pkg::*;

	key_t key;

	hc_key_regs u_key (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key       (key)
	);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	// Each stage loads when it is empty or its content moves on.
	assign en6 = !v_s6 || m_tready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// Stage 1: reduce letters and key into 0..25, pad a missing letter.
	logic    mode_s1;
	letter_t x0_s1, x1_s1;
	key_t    k_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			mode_s1 <= s_tuser[0];
			x0_s1   <= reduce5(s_tdata[4:0]);
			x1_s1   <= s_tuser[1] ? reduce5(s_tdata[9:5]) : '0;
			k_s1.k00 <= reduce5(key.k00);
			k_s1.k01 <= reduce5(key.k01);
			k_s1.k10 <= reduce5(key.k10);
			k_s1.k11 <= reduce5(key.k11);
		end
	end

	// Stage 2: the two determinant products.
	logic       mode_s2;
	letter_t    x0_s2, x1_s2;
	key_t       k_s2;
	logic [9:0] pa_s2, pb_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			mode_s2 <= mode_s1;
			x0_s2   <= x0_s1;
			x1_s2   <= x1_s1;
			k_s2    <= k_s1;
			pa_s2   <= {5'd0, k_s1.k00} * {5'd0, k_s1.k11};
			pb_s2   <= {5'd0, k_s1.k01} * {5'd0, k_s1.k10};
		end
	end

	// Stage 3: determinant modulo 26 and its inverse.
	logic             mode_s3;
	letter_t          x0_s3, x1_s3;
	key_t             k_s3;
	letter_t          inv_s3;
	logic             err_s3;
	logic [WideW-1:0] det_raw;
	letter_t          det_inv;

	assign det_raw = WideW'(pa_s2) + WideW'(DetBias) - WideW'(pb_s2);
	assign det_inv = inv26(mod26(det_raw));

	always_ff @(posedge clk) begin
		if (en3) begin
			mode_s3 <= mode_s2;
			x0_s3   <= x0_s2;
			x1_s3   <= x1_s2;
			k_s3    <= k_s2;
			inv_s3  <= det_inv;
			err_s3  <= (mode_s2 == ModeDecrypt) && (det_inv == '0);
		end
	end

	// Stage 4: pick the key, or scale the adjugate by the inverse.
	letter_t x0_s4, x1_s4;
	key_t    m_s4;
	logic    err_s4;
	logic    use_inv;

	assign use_inv = (mode_s3 == ModeDecrypt) && !err_s3;

	always_ff @(posedge clk) begin
		if (en4) begin
			x0_s4  <= x0_s3;
			x1_s4  <= x1_s3;
			err_s4 <= err_s3;
			if (use_inv) begin
				m_s4.k00 <= mod26({6'd0, k_s3.k11} * {6'd0, inv_s3});
				m_s4.k01 <= mod26({6'd0, neg26(k_s3.k01)} * {6'd0, inv_s3});
				m_s4.k10 <= mod26({6'd0, neg26(k_s3.k10)} * {6'd0, inv_s3});
				m_s4.k11 <= mod26({6'd0, k_s3.k00} * {6'd0, inv_s3});
			end else begin
				m_s4 <= k_s3;
			end
		end
	end

	// Stage 5: matrix times the letter pair.
	logic [WideW-1:0] p0_s5, p1_s5;
	logic             err_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			err_s5 <= err_s4;
			p0_s5  <= {6'd0, m_s4.k00} * {6'd0, x0_s4} + {6'd0, m_s4.k01} * {6'd0, x1_s4};
			p1_s5  <= {6'd0, m_s4.k10} * {6'd0, x0_s4} + {6'd0, m_s4.k11} * {6'd0, x1_s4};
		end
	end

	// Stage 6: final reduction into the output register.
	letter_t r0_s6, r1_s6;
	logic    err_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			err_s6 <= err_s5;
			r0_s6  <= err_s5 ? '0 : mod26(p0_s5);
			r1_s6  <= err_s5 ? '0 : mod26(p1_s5);
		end
	end

	assign m_tvalid = v_s6;
	assign m_tdata  = {6'd0, r1_s6, r0_s6};
	assign m_tuser  = err_s6;

	// A key error always comes with zero letters.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[9:0] == 10'd0)
		else $error("key error with nonzero letters");

	// Result letters are always reduced.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[4:0] < 5'd26) && (m_tdata[9:5] < 5'd26))
		else $error("result letter out of range");

	// With the output register empty, the pipeline never refuses a request.
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output");

endmodule
